/* src/plc_pkg.sv */
// Shared types and constants for the pixel line and circle plotter.
package plc_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = X_W + Y_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int SIZE_W     = 9;
  localparam int POS_W      = 14;
  localparam logic [23:0] WHITE = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ACT_POINT  = 2'd0,
    ACT_LINE   = 2'd1,
    ACT_CIRCLE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POINT,
    ST_LINE,
    ST_CIRC_ADJ,
    ST_CIRC_PLOT,
    ST_READ,
    ST_DONE
  } state_t;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    action_t            action;
    logic signed [11:0] x_a;
    logic signed [11:0] y_a;
    logic signed [11:0] x_b;
    logic signed [11:0] y_b;
    logic [10:0]        radius;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       inside_res;
  } out_t;

  // Decoded job: for a line, (ax,ay) is the start at the low end of the major axis.
  typedef struct packed {
    action_t            act;
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [12:0] d;
    logic [11:0]        len;
    logic               ymaj;
    logic [10:0]        radius;
    logic [23:0]        color;
  } job_t;

endpackage

/* src/plc_ram.sv */
// Generic single-port RAM with registered read.
module plc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* src/plc_front.sv */
// Front end: decodes incoming transactions and queues them for the back end.
module plc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  plc_pkg::in_t  in_data,
  input  logic          clearing,
  output logic          job_valid,
  output plc_pkg::job_t job,
  input  logic          job_pop
);
  plc_pkg::job_t      q [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  plc_pkg::job_t      dec;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic [11:0]        adx;
  logic [11:0]        ady;
  logic               push;

  always_comb begin
    dx  = 13'(in_data.x_b) - 13'(in_data.x_a);
    dy  = 13'(in_data.y_b) - 13'(in_data.y_a);
    adx = dx[12] ? 12'(-dx) : dx[11:0];
    ady = dy[12] ? 12'(-dy) : dy[11:0];
    dec.act    = in_data.action;
    dec.ax     = in_data.x_a;
    dec.ay     = in_data.y_a;
    dec.radius = in_data.radius;
    dec.color  = {in_data.red, in_data.green, in_data.blue};
    dec.ymaj   = (ady > adx);
    dec.d      = 13'sd0;
    dec.len    = 12'd0;
    if (in_data.action == plc_pkg::ACT_LINE) begin
      if (ady > adx) begin
        dec.len = ady;
        dec.d   = dx;
        if (dy[12]) begin
          dec.ax = in_data.x_b;
          dec.ay = in_data.y_b;
          dec.d  = -dx;
        end
      end else begin
        dec.len = adx;
        dec.d   = dy;
        if (dx[12]) begin
          dec.ax = in_data.x_b;
          dec.ay = in_data.y_b;
          dec.d  = -dy;
        end
      end
    end
  end

  assign in_ready  = (count != 2'd2) && !clearing;
  assign push      = in_valid && in_ready;
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(job_pop);
    end
  end
endmodule

/* src/plc_back.sv */
// Back end: clears the frame store, then plots points, lines and circles and reads pixels.
module plc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [plc_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       job_valid,
  input  plc_pkg::job_t              job,
  output logic                       job_pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output plc_pkg::out_t              out_data
);
  plc_pkg::state_t            state;
  plc_pkg::state_t            state_next;
  plc_pkg::job_t              j;
  logic [plc_pkg::SIZE_W-1:0] image_width;
  logic [plc_pkg::SIZE_W-1:0] image_height;
  logic [plc_pkg::SIZE_W-1:0] aw;
  logic [plc_pkg::SIZE_W-1:0] ah;
  logic [plc_pkg::ADDR_W-1:0] clr;
  logic [11:0]                i;
  logic signed [12:0]         off;
  logic signed [15:0]         rem;
  logic signed [15:0]         rem_step;
  logic signed [15:0]         two_len;
  logic signed [11:0]         e;
  logic [21:0]                n;
  logic [10:0]                t;
  logic [21:0]                lo;
  logic [21:0]                hi;
  logic [1:0]                 q;
  plc_pkg::out_t              res;
  plc_pkg::pos_t              px;
  plc_pkg::pos_t              py;
  plc_pkg::pos_t              tt;
  logic                       in_image;
  logic                       ram_we;
  logic [plc_pkg::ADDR_W-1:0] ram_addr;
  logic [23:0]                ram_wdata;
  logic [23:0]                ram_rdata;
  logic                       read_wait;
  logic                       n_above;
  logic                       n_below;
  logic                       out_free;

  assign aw = (image_width  > plc_pkg::SIZE_W'(plc_pkg::MAX_WIDTH))
              ? plc_pkg::SIZE_W'(plc_pkg::MAX_WIDTH) : image_width;
  assign ah = (image_height > plc_pkg::SIZE_W'(plc_pkg::MAX_HEIGHT))
              ? plc_pkg::SIZE_W'(plc_pkg::MAX_HEIGHT) : image_height;

  assign out_free = !out_valid || out_ready;
  assign two_len  = $signed({3'b0, j.len, 1'b0});
  assign rem_step = rem + 16'($signed({j.d, 1'b0}));
  assign n_above  = n > hi;
  assign n_below  = (t != 11'd0) && (n <= lo);
  assign tt       = $signed({3'b0, t});

  // plot coordinate for the current cycle
  always_comb begin
    px = plc_pkg::POS_W'(j.ax);
    py = plc_pkg::POS_W'(j.ay);
    if (state == plc_pkg::ST_LINE) begin
      if (j.ymaj) begin
        px = plc_pkg::POS_W'(j.ax) + plc_pkg::POS_W'(off);
        py = plc_pkg::POS_W'(j.ay) + $signed({2'b0, i});
      end else begin
        px = plc_pkg::POS_W'(j.ax) + $signed({2'b0, i});
        py = plc_pkg::POS_W'(j.ay) + plc_pkg::POS_W'(off);
      end
    end else if (state == plc_pkg::ST_CIRC_PLOT) begin
      unique case (q)
        2'd0: begin
          px = plc_pkg::POS_W'(j.ax) + plc_pkg::POS_W'(e);
          py = plc_pkg::POS_W'(j.ay) + tt;
        end
        2'd1: begin
          px = plc_pkg::POS_W'(j.ax) + plc_pkg::POS_W'(e);
          py = plc_pkg::POS_W'(j.ay) - tt;
        end
        2'd2: begin
          px = plc_pkg::POS_W'(j.ax) - tt;
          py = plc_pkg::POS_W'(j.ay) + plc_pkg::POS_W'(e);
        end
        default: begin
          px = plc_pkg::POS_W'(j.ax) + tt;
          py = plc_pkg::POS_W'(j.ay) + plc_pkg::POS_W'(e);
        end
      endcase
    end
  end

  assign in_image = !px[plc_pkg::POS_W-1] && !py[plc_pkg::POS_W-1]
                    && (px < $signed({5'b0, aw})) && (py < $signed({5'b0, ah}));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      plc_pkg::ST_CLEAR:
        if (clr == '1) state_next = plc_pkg::ST_IDLE;
      plc_pkg::ST_IDLE:
        if (job_valid) begin
          unique case (job.act)
            plc_pkg::ACT_POINT:  state_next = plc_pkg::ST_POINT;
            plc_pkg::ACT_LINE:   state_next = plc_pkg::ST_LINE;
            plc_pkg::ACT_CIRCLE: state_next = plc_pkg::ST_CIRC_ADJ;
            default:             state_next = plc_pkg::ST_READ;
          endcase
        end
      plc_pkg::ST_POINT:
        state_next = plc_pkg::ST_DONE;
      plc_pkg::ST_LINE:
        if (i == j.len) state_next = plc_pkg::ST_DONE;
      plc_pkg::ST_CIRC_ADJ:
        if (!n_above && !n_below) state_next = plc_pkg::ST_CIRC_PLOT;
      plc_pkg::ST_CIRC_PLOT:
        if (q == 2'd3) begin
          state_next = (e == $signed({1'b0, j.radius})) ? plc_pkg::ST_DONE
                                                         : plc_pkg::ST_CIRC_ADJ;
        end
      plc_pkg::ST_READ:
        if (read_wait) state_next = plc_pkg::ST_DONE;
      plc_pkg::ST_DONE:
        if (out_free) state_next = plc_pkg::ST_IDLE;
      default:
        state_next = plc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    job_pop   = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {py[plc_pkg::Y_W-1:0], px[plc_pkg::X_W-1:0]};
    ram_wdata = j.color;
    unique case (state)
      plc_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr;
        ram_wdata = plc_pkg::WHITE;
      end
      plc_pkg::ST_IDLE:      job_pop = job_valid;
      plc_pkg::ST_POINT,
      plc_pkg::ST_LINE,
      plc_pkg::ST_CIRC_PLOT: ram_we = in_image;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= plc_pkg::ST_CLEAR;
      clr          <= '0;
      out_valid    <= 1'b0;
      read_wait    <= 1'b0;
      image_width  <= plc_pkg::SIZE_W'(256);
      image_height <= plc_pkg::SIZE_W'(256);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == plc_pkg::REG_WIDTH)  image_width  <= cfg_data;
        if (cfg_index == plc_pkg::REG_HEIGHT) image_height <= cfg_data;
      end
      if (state == plc_pkg::ST_CLEAR) clr <= clr + 1'b1;
      read_wait <= (state == plc_pkg::ST_READ) && !read_wait;
      if (out_ready) out_valid <= 1'b0;
      if (state == plc_pkg::ST_DONE && out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == plc_pkg::ST_DONE && out_free) out_data <= res;
    unique case (state)
      plc_pkg::ST_IDLE: begin
        j   <= job;
        res <= '0;
        i   <= '0;
        off <= '0;
        rem <= $signed({4'b0, job.len});
        e   <= -$signed({1'b0, job.radius});
        n   <= '0;
        t   <= '0;
        lo  <= '0;
        hi  <= '0;
        q   <= '0;
      end
      plc_pkg::ST_LINE: begin
        i <= i + 1'b1;
        if (rem_step >= two_len) begin
          rem <= rem_step - two_len;
          off <= off + 1'b1;
        end else if (rem_step < 0) begin
          rem <= rem_step + two_len;
          off <= off - 1'b1;
        end else begin
          rem <= rem_step;
        end
      end
      plc_pkg::ST_CIRC_ADJ: begin
        // keep t*t - t < n <= t*t + t, i.e. t = round(sqrt(n))
        if (n_above) begin
          t  <= t + 1'b1;
          lo <= hi;
          hi <= hi + 22'({t, 1'b0}) + 22'd2;
        end else if (n_below) begin
          t  <= t - 1'b1;
          hi <= lo;
          lo <= lo - 22'({t, 1'b0}) + 22'd2;
        end
      end
      plc_pkg::ST_CIRC_PLOT: begin
        q <= q + 1'b1;
        if (q == 2'd3) begin
          e <= e + 1'b1;
          n <= 22'($signed({2'b0, n}) - ($signed({{12{e[11]}}, e}) * 24'sd2 + 24'sd1));
        end
      end
      plc_pkg::ST_READ: begin
        if (!read_wait) begin
          res.inside_res <= in_image;
        end else if (res.inside_res) begin
          res.pixel_red   <= ram_rdata[23:16];
          res.pixel_green <= ram_rdata[15:8];
          res.pixel_blue  <= ram_rdata[7:0];
        end
      end
      default: ;
    endcase
  end

  plc_ram #(
    .WIDTH(24),
    .DEPTH(plc_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );
endmodule

/* src/pixel_line_circle_plotter_top.sv */
// Top level of the pixel line and circle plotter.
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data (plc_pkg::in_t)
//   out      output     out_valid / out_ready out_data (plc_pkg::out_t)
//   cfg      input      cfg_we                cfg_index, cfg_data
// The back end writes at most one pixel per cycle through the single frame-store port.
// After reset a clearing pass writes white to all 65536 pixels, one per cycle;
// in_ready stays low during it. A two-entry queue decouples intake from drawing,
// and a stalled out channel holds the back end in its final state.
module pixel_line_circle_plotter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  plc_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output plc_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [plc_pkg::SIZE_W-1:0] cfg_data
);
  logic          job_valid;
  logic          job_pop;
  logic          clearing;
  plc_pkg::job_t job;

  plc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .clearing (clearing),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop)
  );

  plc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );
endmodule

/* src/plc_checker.sv */
// Port-level assertions for the plotter, bound to the top level.
module plc_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input plc_pkg::out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_clear_blocks: assert property (@(posedge clk)
    !rst && $past(rst) |-> !in_ready)
    else $error("input taken during frame clear");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.inside_res |->
      out_data.pixel_red == 8'd0 && out_data.pixel_green == 8'd0 &&
      out_data.pixel_blue == 8'd0)
    else $error("nonzero color without inside flag");

  a_no_reset_out: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind pixel_line_circle_plotter_top plc_checker u_plc_checker (.*);
